// ----- hw/rtl/xtea_pkg.sv -----
package xtea_pkg;

   localparam int unsigned ROUND_COUNT = 32;
   localparam int unsigned HALF_ROUNDS = 2 * ROUND_COUNT;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned KEY_WORDS   = 4;
   localparam int unsigned KEY_IDX_W   = $clog2(KEY_WORDS);
   localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

   // Bits of sum that pick the key word on the second half of a round.
   localparam int unsigned KEY_SEL_LSB = 11;

   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [KEY_IDX_W-1:0] {
      KEY_WORD_0 = 2'd0,
      KEY_WORD_1 = 2'd1,
      KEY_WORD_2 = 2'd2,
      KEY_WORD_3 = 2'd3
   } key_index_type;

   // Value of sum after the given number of delta steps, modulo 2^32.
   function automatic word_type round_sum(input int unsigned steps);
      logic [63:0] prod;
      prod = 64'(steps) * 64'(DELTA);
      return prod[WORD_W-1:0];
   endfunction

   function automatic word_type mix_word(input word_type w);
      return ((w << 4) ^ (w >> 5)) + w;
   endfunction

endpackage

// ----- hw/rtl/xtea_block_encrypt_core.sv -----
// XTEA encryption engine (32 rounds, delta 0x9E3779B9) under a 128-bit key held in four
// key registers written through the csr_ port. Each half-round has its own register stage,
// so a block passes an input register, 64 round stages and leaves from the last one.
// One block is taken in every cycle while results are drained. When the result word
// is stalled, the stages behind it keep moving, the input with them, until a word reaches
// the stage just before the output; bubbles further back are not squeezed out.
// The key may only be changed while no block is in flight.
module xtea_block_encrypt_core (
   input  logic        clock,
   input  logic        reset,
   // Key register write port.
   input  logic        csr_wr_en,
   input  logic [xtea_pkg::KEY_IDX_W-1:0] csr_index,
   input  logic [xtea_pkg::WORD_W-1:0]    csr_wdata,
   // Plaintext words.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] plain_low_word, [63:32] plain_high_word
   // Ciphertext words.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [31:0] cipher_low_word, [63:32] cipher_high_word
);

   localparam int unsigned LAST = xtea_pkg::HALF_ROUNDS;

   xtea_pkg::word_type key_ff [xtea_pkg::KEY_WORDS];
   xtea_pkg::word_type v0_ff  [LAST+1];
   xtea_pkg::word_type v1_ff  [LAST+1];
   xtea_pkg::word_type v0_in  [LAST+1];
   xtea_pkg::word_type v1_in  [LAST+1];
   logic [LAST:0]      valid_ff;
   logic [LAST:0]      valid_in;
   logic               out_en;
   logic               pipe_en;

   // The output stage moves when it is empty or being taken; the stages behind it may
   // also move when the stage feeding the output holds nothing.
   assign out_en     = !valid_ff[LAST] || rsp_tready;
   assign pipe_en    = out_en || !valid_ff[LAST-1];
   assign req_tready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < xtea_pkg::KEY_WORDS; k++) begin
            key_ff[k] <= '0;
         end
      end else if (csr_wr_en) begin
         case (xtea_pkg::key_index_type'(csr_index))
            xtea_pkg::KEY_WORD_0: key_ff[0] <= csr_wdata;
            xtea_pkg::KEY_WORD_1: key_ff[1] <= csr_wdata;
            xtea_pkg::KEY_WORD_2: key_ff[2] <= csr_wdata;
            xtea_pkg::KEY_WORD_3: key_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign v0_in[0]    = req_tdata[31:0];
   assign v1_in[0]    = req_tdata[63:32];
   assign valid_in[0] = req_tvalid;

   genvar h;
   generate
      for (h = 0; h < LAST; h++) begin : g_half
         if ((h % 2) == 0) begin : g_even
            // First half of the round: sum has taken h/2 delta steps.
            localparam xtea_pkg::word_type SUM = xtea_pkg::round_sum(h / 2);
            localparam xtea_pkg::key_index_type KSEL =
               xtea_pkg::key_index_type'(SUM[1:0]);
            xtea_pkg::word_type rk;
            assign rk         = SUM + key_ff[KSEL];
            assign v0_in[h+1] = v0_ff[h] + (xtea_pkg::mix_word(v1_ff[h]) ^ rk);
            assign v1_in[h+1] = v1_ff[h];
         end else begin : g_odd
            // Second half: sum has already advanced by one more delta.
            localparam xtea_pkg::word_type SUM = xtea_pkg::round_sum(h / 2 + 1);
            localparam xtea_pkg::key_index_type KSEL =
               xtea_pkg::key_index_type'(SUM[xtea_pkg::KEY_SEL_LSB +: xtea_pkg::KEY_IDX_W]);
            xtea_pkg::word_type rk;
            assign rk         = SUM + key_ff[KSEL];
            assign v0_in[h+1] = v0_ff[h];
            assign v1_in[h+1] = v1_ff[h] + (xtea_pkg::mix_word(v0_ff[h]) ^ rk);
         end
         assign valid_in[h+1] = valid_ff[h];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (pipe_en) begin
            valid_ff[LAST-1:0] <= valid_in[LAST-1:0];
         end
         if (out_en) begin
            valid_ff[LAST] <= valid_in[LAST];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int s = 0; s < LAST; s++) begin
            v0_ff[s] <= v0_in[s];
            v1_ff[s] <= v1_in[s];
         end
      end
      if (out_en) begin
         v0_ff[LAST] <= v0_in[LAST];
         v1_ff[LAST] <= v1_in[LAST];
      end
   end

   assign rsp_tvalid = valid_ff[LAST];
   assign rsp_tdata  = {v1_ff[LAST], v0_ff[LAST]};

   // The input is only held back by a stalled result with a word right behind it.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready && valid_ff[LAST-1]))
      else $error("input held without a stalled result");

   // An accepted word always lands in the input stage.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[0])
      else $error("accepted word lost at the input stage");

   // A stalled result stays and the word behind it is not overwritten.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && valid_ff[LAST-1])
         |=> (rsp_tvalid && valid_ff[LAST-1] && $stable(rsp_tdata)))
      else $error("stalled result or its follower was dropped");

   // The pipeline is empty straight after reset.
   assert property (@(posedge clock) $past(reset) |-> (valid_ff == '0))
      else $error("pipeline not empty after reset");

endmodule
